// ===== rtl/core/glob_pkg.sv =====
// glob matcher package: field widths, command codes and character constants
`default_nettype none

package glob_pkg;

    localparam int CMD_W      = 2;
    localparam int POS_W      = 6;
    localparam int SLOT_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int USED_W     = 3;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    typedef logic [CMD_W-1:0] cmd_t;

    localparam cmd_t CMD_RANGE = 2'd0;
    localparam cmd_t CMD_FLAGS = 2'd1;
    localparam cmd_t CMD_BYTE  = 2'd2;
    localparam cmd_t CMD_END   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_FINAL_STATE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIDE_DOT    = 1'd1;

    localparam logic [CHAR_W-1:0] STAR_LOW  = 8'd1;
    localparam logic [CHAR_W-1:0] STAR_HIGH = 8'd255;
    localparam logic [CHAR_W-1:0] DOT_BYTE  = 8'h2E;

    typedef struct packed {
        cmd_t                cmd;
        logic [POS_W-1:0]    position;
        logic [SLOT_W-1:0]   slot;
        logic [CHAR_W-1:0]   low_char;
        logic [CHAR_W-1:0]   high_char;
        logic                negated;
        logic                star_flag;
        logic [USED_W-1:0]   ranges_used;
        logic [CHAR_W-1:0]   text_byte;
    } item_t;

endpackage

`default_nettype wire

// ===== rtl/core/glob_wildcard_matcher.sv =====
// glob matcher top level: pattern tables, parallel nfa update and result register
//
// Takes one item per clock, any mix of pattern writes, text bytes and end items,
// as long as results are taken. Every item passes an input register; on the
// following cycle all pattern states advance together in one update of the
// active-state register; an end item's result then passes the result register
// to m_tdata. The result register lets new items enter while a result
// waits; only an end item meeting a full, stalled result register holds the input.
// Pattern tables sit in flip-flops cleared by reset, so the block is usable at once.
`default_nettype none

module glob_wildcard_matcher #(
    parameter int POSITIONS           = 32,
    parameter int RANGES_PER_POSITION = 4
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    // position[5:0], slot[7:6], low_char[15:8], high_char[23:16], negated[24],
    // star_flag[25], ranges_used[28:26], text_byte[36:29], zero[39:37]
    input  wire logic [glob_pkg::S_TDATA_W-1:0]    s_tdata,
    // cmd[1:0]
    input  wire logic [glob_pkg::CMD_W-1:0]        s_tuser,
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    // matched[0], zero[7:1]
    output      logic [glob_pkg::M_TDATA_W-1:0]    m_tdata,
    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [glob_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [glob_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import glob_pkg::*;

    localparam int NSTATES = POSITIONS + 1;
    localparam int CNT_W   = $clog2(RANGES_PER_POSITION + 1);

    logic [CHAR_W-1:0] range_low_reg  [POSITIONS][RANGES_PER_POSITION];
    logic [CHAR_W-1:0] range_high_reg [POSITIONS][RANGES_PER_POSITION];
    logic [CNT_W-1:0]  range_count_reg [NSTATES];
    logic [NSTATES-1:0] negated_reg;
    logic [NSTATES-1:0] self_loop_reg;
    logic [NSTATES-1:0] active_reg, active_next;
    logic              at_start_reg;
    logic              dot_reject_reg;
    logic [POS_W-1:0]  final_state_reg;
    logic              hide_dot_reg;

    item_t             item_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              matched_reg;

    logic              advance;
    logic              is_end;
    logic [POSITIONS-1:0] class_hit;
    logic              final_active;
    logic              match_now;
    logic [CNT_W-1:0]  used_sat;

    assign is_end   = (item_reg.cmd == CMD_END);
    assign advance  = in_valid_reg && (!is_end || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, matched_reg};

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.cmd         <= s_tuser;
            item_reg.position    <= s_tdata[5:0];
            item_reg.slot        <= s_tdata[7:6];
            item_reg.low_char    <= s_tdata[15:8];
            item_reg.high_char   <= s_tdata[23:16];
            item_reg.negated     <= s_tdata[24];
            item_reg.star_flag   <= s_tdata[25];
            item_reg.ranges_used <= s_tdata[28:26];
            item_reg.text_byte   <= s_tdata[36:29];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            final_state_reg <= '0;
            hide_dot_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FINAL_STATE: final_state_reg <= cfg_data;
                REG_HIDE_DOT:    hide_dot_reg    <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign used_sat = (32'(item_reg.ranges_used) > RANGES_PER_POSITION)
                    ? CNT_W'(RANGES_PER_POSITION) : CNT_W'(item_reg.ranges_used);

    // pattern tables, written through per-entry decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < POSITIONS; p++)
            begin
                for (int k = 0; k < RANGES_PER_POSITION; k++)
                begin
                    range_low_reg[p][k]  <= '0;
                    range_high_reg[p][k] <= '0;
                end
            end
            for (int p = 0; p < NSTATES; p++)
            begin
                range_count_reg[p] <= '0;
            end
            negated_reg   <= '0;
            self_loop_reg <= '0;
        end
        else if (advance)
        begin
            for (int p = 0; p < POSITIONS; p++)
            begin
                for (int k = 0; k < RANGES_PER_POSITION; k++)
                begin
                    if (item_reg.cmd == CMD_RANGE && 32'(item_reg.position) == p
                        && 32'(item_reg.slot) == k)
                    begin
                        range_low_reg[p][k]  <= item_reg.low_char;
                        range_high_reg[p][k] <= item_reg.high_char;
                    end
                end
            end
            for (int p = 0; p < NSTATES; p++)
            begin
                if (item_reg.cmd == CMD_FLAGS && 32'(item_reg.position) == p)
                begin
                    range_count_reg[p] <= used_sat;
                    negated_reg[p]     <= item_reg.negated;
                    self_loop_reg[p]   <= item_reg.star_flag;
                end
            end
        end
    end

    // class compare for every position in parallel
    always_comb
    begin
        logic hit;
        for (int p = 0; p < POSITIONS; p++)
        begin
            hit = 1'b0;
            for (int k = 0; k < RANGES_PER_POSITION; k++)
            begin
                if (32'(range_count_reg[p]) > k
                    && range_low_reg[p][k] <= item_reg.text_byte
                    && item_reg.text_byte <= range_high_reg[p][k])
                begin
                    hit = 1'b1;
                end
            end
            class_hit[p] = (range_count_reg[p] != '0) && (hit ^ negated_reg[p]);
        end
    end

    always_comb
    begin
        for (int p = 0; p < NSTATES; p++)
        begin
            active_next[p] = active_reg[p] && self_loop_reg[p]
                          && item_reg.text_byte >= STAR_LOW
                          && item_reg.text_byte <= STAR_HIGH;
            if (p > 0)
            begin
                active_next[p] = active_next[p] || (active_reg[p-1] && class_hit[p-1]);
            end
        end
    end

    always_comb
    begin
        final_active = 1'b0;
        for (int p = 0; p < NSTATES; p++)
        begin
            if (32'(final_state_reg) == p)
            begin
                final_active = active_reg[p];
            end
        end
    end

    assign match_now = final_active && !dot_reject_reg;

    // nfa state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= NSTATES'(1);
            at_start_reg   <= 1'b1;
            dot_reject_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (item_reg.cmd == CMD_BYTE)
            begin
                active_reg   <= active_next;
                at_start_reg <= 1'b0;
                if (at_start_reg && hide_dot_reg && item_reg.text_byte == DOT_BYTE)
                begin
                    dot_reject_reg <= 1'b1;
                end
            end
            else if (is_end)
            begin
                active_reg     <= NSTATES'(1);
                at_start_reg   <= 1'b1;
                dot_reject_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && is_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_end)
        begin
            matched_reg <= match_now;
        end
    end

    // a restart leaves only the start state active
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_end |=> active_reg == NSTATES'(1) && at_start_reg)
        else $error("active set not restarted after end of string");

    // a new result only appears after an end item left the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && is_end))
        else $error("result without end item");

    // a dot rejection needs the rule enabled and a first byte
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dot_reject_reg) |-> $past(hide_dot_reg && at_start_reg))
        else $error("dot rejection without rule");

    // input held only behind a waiting end item
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && is_end && out_valid_reg && !m_tready)
        else $error("input stalled without cause");

endmodule

`default_nettype wire
